// ===== src/fet_pkg.sv =====
// Package for the fade envelope timer: sequencer control word, op codes and microcode ROM.
`timescale 1ns / 1ps
package fet_pkg;

  localparam int PC_W = 5;

  // datapath ops
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_WAIT  = 4'd1;
  localparam logic [3:0] OP_ACC   = 4'd2;
  localparam logic [3:0] OP_ADDF  = 4'd3;
  localparam logic [3:0] OP_ADDH  = 4'd4;
  localparam logic [3:0] OP_ADDG  = 4'd5;
  localparam logic [3:0] OP_XRISE = 4'd6;
  localparam logic [3:0] OP_XFALL = 4'd7;
  localparam logic [3:0] OP_NUM   = 4'd8;
  localparam logic [3:0] OP_DIV   = 4'd9;
  localparam logic [3:0] OP_EMIT  = 4'd10;

  // branch conditions: taken -> target, else pc + 1
  localparam logic [2:0] CND_NONE    = 3'd0;
  localparam logic [2:0] CND_ALWAYS  = 3'd1;
  localparam logic [2:0] CND_NOIN    = 3'd2;
  localparam logic [2:0] CND_OFF     = 3'd3;
  localparam logic [2:0] CND_LT      = 3'd4;
  localparam logic [2:0] CND_PERSIST = 3'd5;
  localparam logic [2:0] CND_DIVMORE = 3'd6;

  // alpha source for emit
  localparam logic [1:0] ASEL_ZERO  = 2'd0;
  localparam logic [1:0] ASEL_FULL  = 2'd1;
  localparam logic [1:0] ASEL_LEVEL = 2'd2;
  localparam logic [1:0] ASEL_QUOT  = 2'd3;

  // phase codes
  localparam logic [2:0] PH_DELAY = 3'd0;
  localparam logic [2:0] PH_RISE  = 3'd1;
  localparam logic [2:0] PH_HOLD  = 3'd2;
  localparam logic [2:0] PH_FALL  = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [2:0] PH_OFF   = 3'd5;

  // register indexes
  localparam logic [7:0] REG_DELAY = 8'd0;
  localparam logic [7:0] REG_RISE  = 8'd1;
  localparam logic [7:0] REG_HOLD  = 8'd2;
  localparam logic [7:0] REG_FALL  = 8'd3;

  localparam logic [15:0] FULL_LEVEL = 16'hFFFF;
  localparam logic [PC_W-1:0] PC_LAST = 5'd20;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
    logic [1:0]      asel;
    logic [2:0]      ph;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: CND_ALWAYS, target: 5'd0, asel: ASEL_ZERO, ph: PH_DELAY};
    case (pc)
      5'd0:  w = '{op: OP_WAIT,  cond: CND_NOIN,    target: 5'd0,  asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd1:  w = '{op: OP_ACC,   cond: CND_OFF,     target: 5'd18, asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd2:  w = '{op: OP_NOP,   cond: CND_LT,      target: 5'd19, asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd3:  w = '{op: OP_ADDF,  cond: CND_NONE,    target: 5'd0,  asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd4:  w = '{op: OP_XRISE, cond: CND_LT,      target: 5'd12, asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd5:  w = '{op: OP_NOP,   cond: CND_PERSIST, target: 5'd20, asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd6:  w = '{op: OP_ADDH,  cond: CND_NONE,    target: 5'd0,  asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd7:  w = '{op: OP_NOP,   cond: CND_LT,      target: 5'd20, asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd8:  w = '{op: OP_ADDG,  cond: CND_NONE,    target: 5'd0,  asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd9:  w = '{op: OP_XFALL, cond: CND_LT,      target: 5'd15, asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd10: w = '{op: OP_EMIT,  cond: CND_ALWAYS,  target: 5'd0,  asel: ASEL_ZERO,  ph: PH_DONE};
      5'd12: w = '{op: OP_NUM,   cond: CND_NONE,    target: 5'd0,  asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd13: w = '{op: OP_DIV,   cond: CND_DIVMORE, target: 5'd13, asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd14: w = '{op: OP_EMIT,  cond: CND_ALWAYS,  target: 5'd0,  asel: ASEL_QUOT,  ph: PH_RISE};
      5'd15: w = '{op: OP_NUM,   cond: CND_NONE,    target: 5'd0,  asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd16: w = '{op: OP_DIV,   cond: CND_DIVMORE, target: 5'd16, asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd17: w = '{op: OP_EMIT,  cond: CND_ALWAYS,  target: 5'd0,  asel: ASEL_QUOT,  ph: PH_FALL};
      5'd18: w = '{op: OP_EMIT,  cond: CND_ALWAYS,  target: 5'd0,  asel: ASEL_LEVEL, ph: PH_OFF};
      5'd19: w = '{op: OP_EMIT,  cond: CND_ALWAYS,  target: 5'd0,  asel: ASEL_ZERO,  ph: PH_DELAY};
      5'd20: w = '{op: OP_EMIT,  cond: CND_ALWAYS,  target: 5'd0,  asel: ASEL_FULL,  ph: PH_HOLD};
      default: w = '{op: OP_NOP, cond: CND_ALWAYS,  target: 5'd0,  asel: ASEL_ZERO,  ph: PH_DELAY};
    endcase
    return w;
  endfunction

endpackage

// ===== src/fade_envelope_timer.sv =====
// Fade envelope timer: microcoded sequencer with a shared radix-2 ramp divider.
`timescale 1ns / 1ps
// Usage:
//   Tick requests arrive on in_valid/in_ready with time_step; each produces one
//   result on out_valid/out_ready carrying alpha_out, phase and finished.
//   Registers 0..3 (delay, fade-in, hold, fade-out lengths) are written over
//   cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high
//   and writes are meant for idle periods. Other indexes are ignored.
// Timing:
//   A microprogram in a ROM walks the phase boundaries one add/compare per
//   cycle; ramp phases then run a 16-step restoring divider. The next
//   request is taken in the cycle after the result is loaded, so requests
//   are worked one at a time.
// Reset:
//   Registers and the elapsed time clear to zero, the kept level to full, and
//   the sequencer returns to its wait step with no result pending.
// Back-pressure:
//   The result sits in an output register; while it is not taken a new request
//   is still accepted and worked, and the sequencer holds at its emit step.
module fade_envelope_timer
  import fet_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] time_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] alpha_out,
  output logic [2:0]  phase,
  output logic        finished
);

  logic [31:0] fade_in_delay, fade_in_length, hold_length, fade_out_length;
  logic [31:0] elapsed_time;
  logic [15:0] alpha_level;
  logic [15:0] step;
  logic [33:0] bnd;
  logic [31:0] xval;
  logic [31:0] den;
  logic [31:0] rem;
  logic [15:0] lo;
  logic [3:0]  cnt;
  logic [PC_W-1:0] pc;

  ctrl_word_t  cw;
  logic        stall;
  logic        taken;
  logic        lt;
  logic [32:0] acc_sum;
  logic [31:0] acc_sat;
  logic [47:0] num;
  logic [32:0] trial;
  logic [32:0] trial_diff;
  logic [15:0] emit_alpha;

  assign cw        = ucode(pc);
  assign cfg_ready = 1'b1;
  assign in_ready  = (cw.op == OP_WAIT);
  assign stall     = (cw.op == OP_EMIT) && out_valid && !out_ready;
  assign lt        = {2'b00, elapsed_time} < bnd;

  assign acc_sum = {1'b0, elapsed_time} + {17'd0, step};
  assign acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];

  // x * 65535 as (x << 16) - x
  assign num        = {xval, 16'h0000} - {16'h0000, xval};
  assign trial      = {rem, lo[15]};
  assign trial_diff = trial - {1'b0, den};

  always_comb begin
    case (cw.cond)
      CND_NONE:    taken = 1'b0;
      CND_ALWAYS:  taken = 1'b1;
      CND_NOIN:    taken = !in_valid;
      CND_OFF:     taken = (fade_in_delay == 32'd0) && (fade_in_length == 32'd0);
      CND_LT:      taken = lt;
      CND_PERSIST: taken = (hold_length == 32'd0) && (fade_out_length == 32'd0);
      CND_DIVMORE: taken = (cnt != 4'hF);
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.asel)
      ASEL_ZERO:  emit_alpha = 16'h0000;
      ASEL_FULL:  emit_alpha = FULL_LEVEL;
      ASEL_LEVEL: emit_alpha = alpha_level;
      ASEL_QUOT:  emit_alpha = lo;
      default:    emit_alpha = 16'h0000;
    endcase
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc              <= '0;
      out_valid       <= 1'b0;
      elapsed_time    <= '0;
      alpha_level     <= FULL_LEVEL;
      fade_in_delay   <= '0;
      fade_in_length  <= '0;
      hold_length     <= '0;
      fade_out_length <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DELAY: fade_in_delay   <= cfg_data;
          REG_RISE:  fade_in_length  <= cfg_data;
          REG_HOLD:  hold_length     <= cfg_data;
          REG_FALL:  fade_out_length <= cfg_data;
          default: ;
        endcase
      end
      if (!stall && (cw.op == OP_EMIT)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (!stall) begin
        pc <= taken ? cw.target : pc + 1'b1;
        if (cw.op == OP_ACC) begin
          elapsed_time <= acc_sat;
        end
        if (cw.op == OP_EMIT) begin
          alpha_level <= emit_alpha;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!stall) begin
      case (cw.op)
        OP_WAIT:  if (in_valid) step <= time_step;
        OP_ACC:   bnd <= {2'b00, fade_in_delay};
        OP_ADDF:  bnd <= bnd + {2'b00, fade_in_length};
        OP_ADDH:  bnd <= bnd + {2'b00, hold_length};
        OP_ADDG:  bnd <= bnd + {2'b00, fade_out_length};
        OP_XRISE: begin
          xval <= elapsed_time - fade_in_delay;
          den  <= fade_in_length;
        end
        OP_XFALL: begin
          xval <= bnd[31:0] - elapsed_time;
          den  <= fade_out_length;
        end
        OP_NUM: begin
          rem <= num[47:16];
          lo  <= num[15:0];
          cnt <= '0;
        end
        OP_DIV: begin
          if (!trial_diff[32]) begin
            rem <= trial_diff[31:0];
            lo  <= {lo[14:0], 1'b1};
          end else begin
            rem <= trial[31:0];
            lo  <= {lo[14:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
        OP_EMIT: begin
          alpha_out <= emit_alpha;
          phase     <= cw.ph;
          finished  <= (cw.ph == PH_DONE);
        end
        default: ;
      endcase
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc <= PC_LAST)
    else $error("sequencer left the program");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_DIV) |-> (den != 32'd0))
    else $error("ramp divide by zero length");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |-> (phase == PH_DONE && alpha_out == 16'h0000))
    else $error("finished result not at zero");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_DIV) |-> (rem < den))
    else $error("divider remainder out of range");

endmodule
